### hw/rtl/rft_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rft_pkg
// Shared constants, register indexes and types of the rail fence core.
// ---------------------------------------------------------------------------
package rft_pkg;

	localparam int MaxLenDef = 64;
	localparam int LenW      = 7;
	localparam int RailsW    = 7;
	localparam int PosW      = 8;
	localparam int CharW     = 8;
	localparam int Banks     = 2;
	localparam int BankW     = 1;
	localparam int CntW      = 2;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 7;

	localparam logic [CfgIdxW-1:0] RegRails = 1'd0;
	localparam logic [CfgIdxW-1:0] RegMode  = 1'd1;

	localparam logic [RailsW-1:0] RailsRst = 7'd2;
	localparam logic              ModeEnc  = 1'b0;
	localparam logic              ModeDec  = 1'b1;

	// One complete message waiting in a buffer bank.
	typedef struct packed {
		logic [LenW-1:0]   len;
		logic              ovf;
		logic [RailsW-1:0] rails;
		logic              mode;
	} rft_desc_t;

	typedef struct packed {
		logic active;
		logic pop;
	} rft_back_stat_t;

endpackage
`default_nettype wire

### hw/rtl/rail_fence_transposition_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rail_fence_transposition_core
// Rail fence transposition of byte messages, encrypt or decrypt.
// ---------------------------------------------------------------------------
// Usage: write rails (index 0) and mode (index 1) on the cfg port while the
// core is idle. Present message bytes on char_in with start high; a byte is
// transferred on each edge with start high and busy low, one per cycle.
// last_in marks the final byte. Messages longer than MaxLen are truncated
// and every result of such a message carries overflow.
// Two buffer banks let the next message load while the previous one is
// being transposed; busy rises only when both banks hold messages.
// Results appear on char_out with result_valid high for exactly one cycle
// each, one per cycle, last_out on the final byte; the receiver cannot
// stall. Encrypt: with the engine idle, the first result follows the last byte
// through the queue, the idle state, the bank read and the output register,
// then len results back to back. Decrypt adds a scatter pass of len bytes and
// a gap state that lets the last scattered byte land in the reorder buffer
// before the in-order read. Reset clears all control state and returns the
// registers to rails 2 and encrypt; no clearing pass is needed.
// ---------------------------------------------------------------------------
module rail_fence_transposition_core #(
	parameter int MaxLen = rft_pkg::MaxLenDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rft_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [rft_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rft_pkg::CharW-1:0]     char_in,
	input  wire logic                          last_in,
	output logic                               result_valid,
	output logic [rft_pkg::CharW-1:0]          char_out,
	output logic                               last_out,
	output logic                               overflow
);

	localparam int AW = $clog2(MaxLen);

	logic                              st_we;
	logic [rft_pkg::BankW+AW-1:0]      st_waddr;
	logic [rft_pkg::CharW-1:0]         st_wdata;
	logic [rft_pkg::BankW+AW-1:0]      st_raddr;
	logic [rft_pkg::CharW-1:0]         st_rdata;
	logic                              q_push;
	rft_pkg::rft_desc_t                q_push_desc;
	rft_pkg::rft_desc_t                q_head_desc;
	logic [rft_pkg::BankW-1:0]         q_head_bank;
	logic [rft_pkg::BankW-1:0]         q_tail_bank;
	logic [rft_pkg::CntW-1:0]          q_count;
	logic                              q_full;
	rft_pkg::rft_back_stat_t           bk_stat;

	rft_front #(
		.MaxLen (MaxLen)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.char_in   (char_in),
		.last_in   (last_in),
		.full      (q_full),
		.wr_bank   (q_tail_bank),
		.busy      (busy),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.push      (q_push),
		.push_desc (q_push_desc)
	);

	rft_ram #(
		.Width (rft_pkg::CharW),
		.Depth (rft_pkg::Banks << AW)
	) u_store_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	rft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_push_desc),
		.pop       (bk_stat.pop),
		.head_desc (q_head_desc),
		.head_bank (q_head_bank),
		.tail_bank (q_tail_bank),
		.count     (q_count),
		.full      (q_full)
	);

	rft_back #(
		.MaxLen (MaxLen)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_count != '0),
		.q_desc       (q_head_desc),
		.q_bank       (q_head_bank),
		.st_raddr     (st_raddr),
		.st_rdata     (st_rdata),
		.stat         (bk_stat),
		.result_valid (result_valid),
		.char_out     (char_out),
		.last_out     (last_out),
		.overflow     (overflow)
	);

	// A message is retired only after it was queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> (q_count != '0))
		else $error("descriptor retired from an empty queue");

	// The front never overwrites the bank that the back is still reading.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && bk_stat.active) |-> (st_waddr[rft_pkg::BankW+AW-1:AW] != q_head_bank))
		else $error("intake write into the bank under transposition");

	// Intake stalls exactly when both banks are taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy == (q_count == rft_pkg::CntW'(rft_pkg::Banks)))
		else $error("busy disagrees with the bank occupancy");

	// The transposition engine reads only while it holds a queued message.
	assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.active |-> (q_count != '0))
		else $error("transposition running without a queued message");

endmodule
`default_nettype wire

### hw/rtl/rft_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rft_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module rft_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/rft_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rft_front
// Configuration registers and message intake: stores bytes into the free
// buffer bank and hands a descriptor to the queue on the last byte.
// ---------------------------------------------------------------------------
module rft_front #(
	parameter int MaxLen = rft_pkg::MaxLenDef,
	localparam int AW = $clog2(MaxLen)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rft_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [rft_pkg::CfgDataW-1:0]   cfg_data,
	input  wire logic                           start,
	input  wire logic [rft_pkg::CharW-1:0]      char_in,
	input  wire logic                           last_in,
	input  wire logic                           full,
	input  wire logic [rft_pkg::BankW-1:0]      wr_bank,
	output logic                                busy,
	output logic                                st_we,
	output logic [rft_pkg::BankW+AW-1:0]        st_waddr,
	output logic [rft_pkg::CharW-1:0]           st_wdata,
	output logic                                push,
	output rft_pkg::rft_desc_t                  push_desc
);

	logic [rft_pkg::RailsW-1:0] rails_q;
	logic                       mode_q;
	logic [rft_pkg::LenW-1:0]   len_q;
	logic                       ovf_q;
	logic                       accept;
	logic                       room;

	assign accept   = start & ~full;
	assign busy     = full;
	assign room     = (len_q != rft_pkg::LenW'(MaxLen));
	assign st_we    = accept & room;
	assign st_waddr = {wr_bank, len_q[AW-1:0]};
	assign st_wdata = char_in;
	assign push     = accept & last_in;

	always_comb begin
		push_desc.len   = room ? len_q + rft_pkg::LenW'(1) : len_q;
		push_desc.ovf   = ovf_q | ~room;
		// Zero rails behaves as one rail.
		push_desc.rails = (rails_q == '0) ? rft_pkg::RailsW'(1) : rails_q;
		push_desc.mode  = mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rails_q <= rft_pkg::RailsRst;
			mode_q  <= rft_pkg::ModeEnc;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rft_pkg::RegRails: rails_q <= cfg_data;
				rft_pkg::RegMode:  mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_in) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				len_q <= len_q + rft_pkg::LenW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/rft_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rft_queue
// Two-entry descriptor queue. Each slot owns one buffer bank, so the slot
// pointers double as bank selects for the front and the back.
// ---------------------------------------------------------------------------
module rft_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire rft_pkg::rft_desc_t          push_desc,
	input  wire logic                        pop,
	output rft_pkg::rft_desc_t               head_desc,
	output logic [rft_pkg::BankW-1:0]        head_bank,
	output logic [rft_pkg::BankW-1:0]        tail_bank,
	output logic [rft_pkg::CntW-1:0]         count,
	output logic                             full
);

	rft_pkg::rft_desc_t               entries_q [rft_pkg::Banks];
	logic [rft_pkg::BankW-1:0]        head_q;
	logic [rft_pkg::BankW-1:0]        tail_q;
	logic [rft_pkg::CntW-1:0]         count_q;

	assign head_desc = entries_q[head_q];
	assign head_bank = head_q;
	assign tail_bank = tail_q;
	assign count     = count_q;
	assign full      = (count_q == rft_pkg::CntW'(rft_pkg::Banks));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[tail_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + rft_pkg::BankW'(1);
			end
			if (pop) begin
				head_q <= head_q + rft_pkg::BankW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + rft_pkg::CntW'(1);
				2'b01:   count_q <= count_q - rft_pkg::CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/rft_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rft_back
// Transposition engine: walks the rails of the zigzag one position per
// cycle and either emits the bytes directly (encrypt) or scatters them into
// a reorder buffer that is then read out in order (decrypt).
// ---------------------------------------------------------------------------
module rft_back #(
	parameter int MaxLen = rft_pkg::MaxLenDef,
	localparam int AW = $clog2(MaxLen)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire rft_pkg::rft_desc_t            q_desc,
	input  wire logic [rft_pkg::BankW-1:0]     q_bank,
	output logic [rft_pkg::BankW+AW-1:0]       st_raddr,
	input  wire logic [rft_pkg::CharW-1:0]     st_rdata,
	output rft_pkg::rft_back_stat_t            stat,
	output logic                               result_valid,
	output logic [rft_pkg::CharW-1:0]          char_out,
	output logic                               last_out,
	output logic                               overflow
);

	typedef enum logic [3:0] {
		BkIdle = 4'b0001,
		BkPerm = 4'b0010,
		BkGap  = 4'b0100,
		BkSeq  = 4'b1000
	} rft_back_state_t;

	rft_back_state_t             state_q;
	logic [rft_pkg::LenW-1:0]    len_q;
	logic                        ovf_q;
	logic [rft_pkg::RailsW-1:0]  rails_q;
	logic                        mode_q;
	logic [rft_pkg::RailsW-1:0]  rail_q;
	logic [rft_pkg::PosW-1:0]    pos_q;
	logic                        dir_q;
	logic [rft_pkg::LenW-1:0]    cnt_q;

	logic                        emit_s1;
	logic                        wr_s1;
	logic                        src_s1;
	logic                        last_s1;
	logic                        ovf_s1;
	logic [AW-1:0]               waddr_s1;

	logic                        result_valid_q;
	logic [rft_pkg::CharW-1:0]   char_q;
	logic                        last_q;
	logic                        overflow_q;

	logic [rft_pkg::LenW-1:0]    cnt_next;
	logic                        is_last;
	logic [rft_pkg::PosW-1:0]    period;
	logic [rft_pkg::PosW-1:0]    lower;
	logic [rft_pkg::PosW-1:0]    upper;
	logic [rft_pkg::PosW-1:0]    step_a;
	logic [rft_pkg::PosW-1:0]    step_b;
	logic [rft_pkg::PosW-1:0]    step;
	logic [rft_pkg::PosW-1:0]    npos;
	logic [rft_pkg::RailsW-1:0]  rail_next;
	logic [rft_pkg::CharW-1:0]   buf_rdata;

	assign cnt_next  = cnt_q + rft_pkg::LenW'(1);
	assign is_last   = (cnt_next == len_q);
	assign rail_next = rail_q + rft_pkg::RailsW'(1);

	// On rail r the gaps between positions alternate between 2(R-1)-2r and 2r;
	// the outer rails have one gap of zero and use the other one throughout.
	always_comb begin
		period = {rails_q, 1'b0} - rft_pkg::PosW'(2);
		lower  = {rail_q, 1'b0};
		upper  = period - lower;
		step_a = dir_q ? lower : upper;
		step_b = dir_q ? upper : lower;
		if (rails_q == rft_pkg::RailsW'(1)) begin
			step = rft_pkg::PosW'(1);
		end else if (step_a != '0) begin
			step = step_a;
		end else begin
			step = step_b;
		end
		npos = pos_q + step;
	end

	assign st_raddr    = {q_bank, (mode_q == rft_pkg::ModeDec) ? cnt_q[AW-1:0] : pos_q[AW-1:0]};
	assign stat.active = (state_q == BkPerm);
	assign stat.pop    = (state_q == BkPerm) & is_last;

	rft_ram #(
		.Width (rft_pkg::CharW),
		.Depth (MaxLen)
	) u_reorder_ram (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (waddr_s1),
		.wdata (st_rdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BkIdle;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			rails_q <= rft_pkg::RailsW'(1);
			mode_q  <= rft_pkg::ModeEnc;
			rail_q  <= '0;
			pos_q   <= '0;
			dir_q   <= 1'b0;
			cnt_q   <= '0;
			emit_s1 <= 1'b0;
			wr_s1   <= 1'b0;
		end else begin
			emit_s1 <= 1'b0;
			wr_s1   <= 1'b0;
			unique case (state_q)
				BkIdle: begin
					if (q_valid) begin
						len_q   <= q_desc.len;
						ovf_q   <= q_desc.ovf;
						rails_q <= q_desc.rails;
						mode_q  <= q_desc.mode;
						rail_q  <= '0;
						pos_q   <= '0;
						dir_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= BkPerm;
					end
				end
				BkPerm: begin
					emit_s1 <= (mode_q == rft_pkg::ModeEnc);
					wr_s1   <= (mode_q == rft_pkg::ModeDec);
					cnt_q   <= cnt_next;
					if (npos >= {1'b0, len_q}) begin
						rail_q <= rail_next;
						pos_q  <= {1'b0, rail_next};
						dir_q  <= 1'b0;
					end else begin
						pos_q <= npos;
						dir_q <= ~dir_q;
					end
					if (is_last) begin
						state_q <= (mode_q == rft_pkg::ModeDec) ? BkGap : BkIdle;
					end
				end
				BkGap: begin
					// Lets the final scatter write land before the in-order read.
					cnt_q   <= '0;
					state_q <= BkSeq;
				end
				BkSeq: begin
					emit_s1 <= 1'b1;
					cnt_q   <= cnt_next;
					if (is_last) begin
						state_q <= BkIdle;
					end
				end
				default: state_q <= BkIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		src_s1   <= (state_q == BkSeq);
		last_s1  <= is_last;
		ovf_s1   <= ovf_q;
		waddr_s1 <= pos_q[AW-1:0];
		char_q     <= src_s1 ? buf_rdata : st_rdata;
		last_q     <= last_s1;
		overflow_q <= ovf_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign char_out     = char_q;
	assign last_out     = last_q;
	assign overflow     = overflow_q;

endmodule
`default_nettype wire
